@@ design/five_channel_timer_with_irq_select_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the five-channel timer core
// Concurrent checks that compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FIVE_CHANNEL_TIMER_WITH_IRQ_SELECT_CORE_ASSERT_SVH
`define FIVE_CHANNEL_TIMER_WITH_IRQ_SELECT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FCTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer core assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define FCTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer core assertion failed");
`else
`define FCTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/fcts_pkg.sv @@
// ----------------------------------------------------------------------------
// fcts_pkg
// Shared constants and types of the five-channel timer core.
// ----------------------------------------------------------------------------
`default_nettype none

package fcts_pkg;

    // Timer array geometry.
    localparam int NUM_TIMERS   = 5;
    localparam int IDX_BITS     = 3;
    localparam int COUNTER_BITS = 32;

    // Field widths.
    localparam int PRE_BITS       = 8;
    localparam int SEL_BITS       = 3;
    localparam int COUNT_BUF_BITS = 16;
    localparam int CNT_EXT_BITS   = 17;
    localparam int ELAPSED_BITS   = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DIVSEL_BITS    = 15;

    // Clock ratio constants.
    localparam int unsigned CLOCK_IN   = 66000000;
    localparam int unsigned CLOCK_REF  = 12000000;
    localparam int unsigned COUNT_WRAP = 32'h0001_0000;

    // Shared divider sizing: dividends and divisors fit in 26 bits.
    localparam int DIV_BITS      = 26;
    localparam int REM_BITS      = DIV_BITS + 1;
    localparam int DIV_STEP_BITS = 5;
    // 12000000 / hz stays below 1024 since hz is at least 16113.
    localparam int QUO_BITS      = 10;
    localparam int PRODUCT_BITS  = QUO_BITS + CNT_EXT_BITS;

    // Most negative counter value.
    localparam logic [COUNTER_BITS-1:0] CTR_MIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_PRESCALERS = 3'd0,
        CFG_DIVSEL     = 3'd1,
        CFG_COUNT0     = 3'd2,
        CFG_COUNT1     = 3'd3,
        CFG_COUNT2     = 3'd4,
        CFG_COUNT3     = 3'd5,
        CFG_COUNT4     = 3'd6,
        CFG_IRQ_MASK   = 3'd7
    } t_cfg_index;

    // Request to the start value calculator.
    typedef struct packed {
        logic                      go;
        logic [PRE_BITS-1:0]       pre;
        logic [SEL_BITS-1:0]       sel;
        logic [COUNT_BUF_BITS-1:0] cnt;
    } t_calc_req;

    // Response of the start value calculator.
    typedef struct packed {
        logic                    done;
        logic [COUNTER_BITS-1:0] value;
    } t_calc_rsp;

endpackage

`default_nettype wire

@@ design/fcts_start_calc.sv @@
// ----------------------------------------------------------------------------
// fcts_start_calc
// Computes a timer start value, (CLOCK_REF / hz) * count, with one shared
// restoring divider used twice and a single registered multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module fcts_start_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcts_pkg::t_calc_req i_req,
    output fcts_pkg::t_calc_rsp o_rsp
);
    import fcts_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_DIV1 = 4'b0010,
        C_DIV2 = 4'b0100,
        C_MUL  = 4'b1000
    } t_calc_state;

    t_calc_state               r_state;
    logic [REM_BITS-1:0]       r_rem;
    logic [DIV_BITS-1:0]       r_quo;
    logic [DIV_BITS-1:0]       r_dvs;
    logic [DIV_STEP_BITS-1:0]  r_step;
    logic [SEL_BITS-1:0]       r_sel;
    logic [CNT_EXT_BITS-1:0]   r_cnt;
    logic [COUNTER_BITS-1:0]   r_value;
    logic                      r_done;

    logic [REM_BITS-1:0]       w_rem_sh;
    logic                      w_fits;
    logic [REM_BITS-1:0]       n_rem;
    logic [DIV_BITS-1:0]       n_quo;
    logic [DIV_BITS-1:0]       w_hz;
    logic                      w_last;
    logic [PRODUCT_BITS-1:0]   w_prod;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    assign w_rem_sh = {r_rem[REM_BITS-2:0], r_quo[DIV_BITS-1]};
    assign w_fits   = (w_rem_sh >= {1'b0, r_dvs});
    assign n_rem    = w_fits ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
    assign n_quo    = {r_quo[DIV_BITS-2:0], w_fits};
    assign w_last   = (r_step == DIV_STEP_BITS'(DIV_BITS - 1));

    // Timer clock: selects 0 to 3 divide by 2 to 16, the others pass through.
    assign w_hz = r_sel[2] ? n_quo : (n_quo >> ({1'b0, r_sel[1:0]} + 3'd1));

    // Reload value from the second quotient and the count.
    assign w_prod = r_quo[QUO_BITS-1:0] * r_cnt;

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.go) begin
                        r_quo   <= DIV_BITS'(CLOCK_IN);
                        r_dvs   <= DIV_BITS'(i_req.pre) + DIV_BITS'(1);
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_sel   <= i_req.sel;
                        r_cnt   <= (i_req.cnt == '0) ? CNT_EXT_BITS'(COUNT_WRAP)
                                                     : {1'b0, i_req.cnt};
                        r_state <= C_DIV1;
                    end
                end
                C_DIV1: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + DIV_STEP_BITS'(1);
                    if (w_last) begin
                        r_quo   <= DIV_BITS'(CLOCK_REF);
                        r_dvs   <= w_hz;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= C_DIV2;
                    end
                end
                C_DIV2: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + DIV_STEP_BITS'(1);
                    if (w_last) begin
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_value <= COUNTER_BITS'(w_prod);
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

`default_nettype wire

@@ design/five_channel_timer_with_irq_select_core.sv @@
// ----------------------------------------------------------------------------
// five_channel_timer_with_irq_select_core
// Five down-counting timers with prescalers and a fixed-priority interrupt
// selector, driven by tick and control-write transfers.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one result transfer. A tick transfer
// (tuser = 0) subtracts the elapsed count from every running timer, one
// timer per cycle through a shared subtract and compare unit, then selects
// the lowest unmasked pending timer. A control transfer (tuser = 1) also
// visits every timer in turn, and for every rising start bit waits on the
// start value unit (two 26-step restoring divisions on one divider and a
// multiply). The block is not ready while an item is in progress; a finished
// result waits in the output register while the next item is accepted.
// Configuration writes are taken at any edge with i_cfg_we high and must
// only come while the block is idle.
`default_nettype none
`include "five_channel_timer_with_irq_select_core_assert.svh"

module five_channel_timer_with_irq_select_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_addr,
    input  logic [fcts_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: elapsed[7:0], start_bits[12:8], auto_bits[17:13],
    //        cpu_irq_enable[18], zero[23:19]
    input  logic [23:0]                        s_axis_tdata,
    // tuser: operation[0]
    input  logic [0:0]                         s_axis_tuser,
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: irq_valid[0], irq_timer[3:1], irq_taken[4],
    //        source_pending[9:5], running[14:10], zero[15]
    output logic [15:0]                        m_axis_tdata
);
    import fcts_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TICK = 5'b00010,
        ST_CTRL = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(NUM_TIMERS - 1);

    // Configuration registers.
    logic [CFG_DATA_BITS-1:0]  r_prescalers;
    logic [DIVSEL_BITS-1:0]    r_divsel;
    logic [COUNT_BUF_BITS-1:0] r_count [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]     r_irq_mask;

    // Captured input item.
    logic                      r_op;
    logic [ELAPSED_BITS-1:0]   r_elapsed;
    logic [NUM_TIMERS-1:0]     r_start_in;
    logic [NUM_TIMERS-1:0]     r_auto_in;
    logic                      r_cie;

    // Timer state.
    logic [COUNTER_BITS-1:0]   r_ctr    [NUM_TIMERS];
    logic [COUNTER_BITS-1:0]   r_reload [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]     r_start_prev;
    logic [NUM_TIMERS-1:0]     r_auto;
    logic [NUM_TIMERS-1:0]     r_pend;
    logic [NUM_TIMERS-1:0]     r_src_pend;

    // Sequencer and output register.
    t_state                    r_state;
    logic [IDX_BITS-1:0]       r_idx;
    logic                      r_m_valid;
    logic [15:0]               r_m_data;

    t_calc_req                 w_req;
    t_calc_rsp                 w_rsp;

    // ------------------------------------------------------------------
    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescalers <= '0;
            r_divsel     <= '0;
            r_irq_mask   <= '1;
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_count[t] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_addr))
                CFG_PRESCALERS: r_prescalers <= i_cfg_data;
                CFG_DIVSEL:     r_divsel     <= i_cfg_data[DIVSEL_BITS-1:0];
                CFG_COUNT0:     r_count[0]   <= i_cfg_data;
                CFG_COUNT1:     r_count[1]   <= i_cfg_data;
                CFG_COUNT2:     r_count[2]   <= i_cfg_data;
                CFG_COUNT3:     r_count[3]   <= i_cfg_data;
                CFG_COUNT4:     r_count[4]   <= i_cfg_data;
                CFG_IRQ_MASK:   r_irq_mask   <= i_cfg_data[NUM_TIMERS-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared tick unit: one timer per cycle, selected by r_idx.
    logic [COUNTER_BITS-1:0] w_c;
    logic [COUNTER_BITS-1:0] w_rl;
    logic [COUNTER_BITS:0]   w_diff;
    logic                    w_under;
    logic [COUNTER_BITS-1:0] w_sat;
    logic                    w_expire;
    logic [COUNTER_BITS-1:0] n_tick_ctr;
    logic [COUNTER_BITS-1:0] n_tick_rl;
    logic                    n_tick_exp;

    assign w_c      = r_ctr[r_idx];
    assign w_rl     = r_reload[r_idx];
    assign w_diff   = {w_c[COUNTER_BITS-1], w_c} - (COUNTER_BITS+1)'(r_elapsed);
    assign w_under  = (w_diff[COUNTER_BITS] != w_diff[COUNTER_BITS-1]);
    assign w_sat    = w_under ? CTR_MIN : w_diff[COUNTER_BITS-1:0];
    assign w_expire = w_sat[COUNTER_BITS-1] | (w_sat == '0);

    always_comb begin
        n_tick_ctr = w_c;
        n_tick_rl  = w_rl;
        n_tick_exp = 1'b0;
        if (w_c != '0) begin
            if (w_expire) begin
                n_tick_exp = 1'b1;
                if (r_auto[r_idx]) begin
                    n_tick_ctr = w_sat + w_rl;
                end else begin
                    n_tick_ctr = '0;
                    n_tick_rl  = '0;
                end
            end else begin
                n_tick_ctr = w_sat;
            end
        end
    end

    // ------------------------------------------------------------------
    // Start bit edges and the request to the start value unit.
    logic [NUM_TIMERS-1:0] w_rise;
    logic [NUM_TIMERS-1:0] w_fall;

    assign w_rise = r_start_in & ~r_start_prev;
    assign w_fall = r_start_prev & ~r_start_in;

    assign w_req.go  = (r_state == ST_CTRL) && w_rise[r_idx];
    assign w_req.pre = (r_idx < IDX_BITS'(2)) ? r_prescalers[PRE_BITS-1:0]
                                              : r_prescalers[2*PRE_BITS-1:PRE_BITS];
    assign w_req.sel = r_divsel[r_idx*SEL_BITS +: SEL_BITS];
    assign w_req.cnt = r_count[r_idx];

    fcts_start_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ------------------------------------------------------------------
    // Interrupt selection and result assembly.
    logic [NUM_TIMERS-1:0] w_avail;
    logic                  w_valid;
    logic [IDX_BITS-1:0]   w_sel;
    logic                  w_taken;
    logic [NUM_TIMERS-1:0] n_src_pend;
    logic [NUM_TIMERS-1:0] w_running;
    logic                  w_out_free;
    logic                  w_idle;
    logic                  w_done_free;

    assign w_avail     = r_pend & ~r_irq_mask;
    assign w_valid     = (w_avail != '0);
    assign w_taken     = w_valid & r_cie;
    assign n_src_pend  = r_src_pend | r_pend;
    assign w_out_free  = !r_m_valid || m_axis_tready;
    assign w_idle      = (r_state == ST_IDLE);
    assign w_done_free = (r_state == ST_DONE) && w_out_free;

    always_comb begin
        w_sel = '0;
        for (int t = NUM_TIMERS - 1; t >= 0; t--) begin
            if (w_avail[t]) begin
                w_sel = IDX_BITS'(t);
            end
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
            w_running[t] = (r_ctr[t] != '0);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_start_prev <= '0;
            r_auto       <= '0;
            r_pend       <= '0;
            r_src_pend   <= '0;
            r_m_valid    <= 1'b0;
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_ctr[t]    <= '0;
                r_reload[t] <= '0;
            end
        end else begin
            // A finished item fills the output register; otherwise the
            // consumer empties it.
            if (w_done_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op       <= s_axis_tuser[0];
                        r_elapsed  <= s_axis_tdata[7:0];
                        r_start_in <= s_axis_tdata[12:8];
                        r_auto_in  <= s_axis_tdata[17:13];
                        r_cie      <= s_axis_tdata[18];
                        r_idx      <= '0;
                        r_state    <= s_axis_tuser[0] ? ST_CTRL : ST_TICK;
                    end
                end
                ST_TICK: begin
                    r_ctr[r_idx]    <= n_tick_ctr;
                    r_reload[r_idx] <= n_tick_rl;
                    if (n_tick_exp) begin
                        r_pend[r_idx] <= 1'b1;
                    end
                    if (r_idx == IDX_LAST) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + IDX_BITS'(1);
                    end
                end
                ST_CTRL: begin
                    if (w_rise[r_idx]) begin
                        r_state <= ST_WAIT;
                    end else begin
                        if (w_fall[r_idx]) begin
                            r_ctr[r_idx]    <= '0;
                            r_reload[r_idx] <= '0;
                        end
                        if (r_idx == IDX_LAST) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_idx <= r_idx + IDX_BITS'(1);
                        end
                    end
                end
                ST_WAIT: begin
                    if (w_rsp.done) begin
                        r_ctr[r_idx]    <= w_rsp.value;
                        r_reload[r_idx] <= w_rsp.value;
                        if (r_idx == IDX_LAST) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_idx   <= r_idx + IDX_BITS'(1);
                            r_state <= ST_CTRL;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        if (r_op) begin
                            r_start_prev <= r_start_in;
                            r_auto       <= r_auto_in;
                        end
                        r_src_pend <= n_src_pend;
                        if (w_valid) begin
                            r_pend[w_sel] <= 1'b0;
                        end
                        r_m_data  <= {1'b0, w_running, n_src_pend, w_taken, w_sel, w_valid};
                        r_idx     <= '0;
                        r_state   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = w_idle;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ------------------------------------------------------------------
    // Assertions.
    `FCTS_ASSERT_IMPL(a_idle_pend_in_src, i_clk, i_rst_n, w_idle, ((r_pend & ~r_src_pend) == '0))
    `FCTS_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, 1'b1, (r_idx <= IDX_LAST))
    `FCTS_ASSERT_IMPL(a_calc_done_when_waiting, i_clk, i_rst_n, w_rsp.done, (r_state == ST_WAIT))
    `FCTS_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_done_free, (m_axis_tvalid && w_idle))

endmodule

`default_nettype wire
